>>> hw/rtl/sm83_pkg.sv
// sm83_pkg: operation codes, flag positions, cycle counts and payload structs
// for the SM83 ALU. No dependencies; used by sm83_core, sm83_alu and tb_sm83_alu.
`timescale 1ns / 1ps
`default_nettype none

package sm83_pkg;

    // Operation codes carried in the func field
    typedef enum logic [4:0] {
        FN_ADD   = 5'd0,
        FN_ADC   = 5'd1,
        FN_SUB   = 5'd2,
        FN_SBC   = 5'd3,
        FN_AND   = 5'd4,
        FN_OR    = 5'd5,
        FN_XOR   = 5'd6,
        FN_CP    = 5'd7,
        FN_INC8  = 5'd8,
        FN_DEC8  = 5'd9,
        FN_ADD16 = 5'd10,
        FN_ADDSP = 5'd11,
        FN_INC16 = 5'd12,
        FN_DEC16 = 5'd13,
        FN_CPL   = 5'd14,
        FN_DAA   = 5'd15,
        FN_SWAP  = 5'd16,
        FN_BIT   = 5'd17,
        FN_SET   = 5'd18,
        FN_RES   = 5'd19,
        FN_RLA   = 5'd20,
        FN_RRA   = 5'd21,
        FN_RLCA  = 5'd22,
        FN_RRCA  = 5'd23,
        FN_RL    = 5'd24,
        FN_RR    = 5'd25,
        FN_RLC   = 5'd26,
        FN_RRC   = 5'd27,
        FN_SLA   = 5'd28,
        FN_SRA   = 5'd29,
        FN_SRL   = 5'd30
    } func_t;

    // Flag bit positions within the 4-bit flag word
    localparam int FL_Z = 3;
    localparam int FL_N = 2;
    localparam int FL_H = 1;
    localparam int FL_C = 0;

    // Reported instruction lengths in clock cycles
    localparam logic [4:0] CYC_4  = 5'd4;
    localparam logic [4:0] CYC_8  = 5'd8;
    localparam logic [4:0] CYC_16 = 5'd16;

    // DAA adjustment constants
    localparam logic [8:0] DAA_LO     = 9'h006;
    localparam logic [8:0] DAA_HI     = 9'h060;
    localparam logic [8:0] DAA_HI_LIM = 9'h09F;

    typedef struct packed {
        logic [4:0]  func;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic [4:0]  cycle_count;
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/sm83_cmd_if.sv
// sm83_cmd_if: valid/ready channel carrying one ALU operation.
// Standalone; field widths match sm83_pkg::alu_req_t.
`timescale 1ns / 1ps
`default_nettype none

interface sm83_cmd_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;

    modport source (
        output valid, func, operand_a, operand_b, bit_index, flags_in,
        input  ready
    );

    modport sink (
        input  valid, func, operand_a, operand_b, bit_index, flags_in,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/sm83_rsp_if.sv
// sm83_rsp_if: valid/ready channel carrying one ALU result.
// Standalone; field widths match sm83_pkg::alu_rsp_t.
`timescale 1ns / 1ps
`default_nettype none

interface sm83_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic [4:0]  cycle_count;

    modport source (
        output valid, result, flags_out, cycle_count,
        input  ready
    );

    modport sink (
        input  valid, result, flags_out, cycle_count,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/sm83_core.sv
// sm83_core: combinational SM83 ALU datapath, one operation in, one result out.
// Depends on sm83_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm83_core
    import sm83_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    function automatic logic zf(input logic [7:0] v);
        zf = (v == 8'h00);
    endfunction

    func_t       fn;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] a16;
    logic [15:0] b16;
    logic [3:0]  fi;
    logic        cin;

    logic        add_cin;
    logic [8:0]  add_r;
    logic [4:0]  add_h;
    logic        sub_bin;
    logic [8:0]  sub_r;
    logic [4:0]  sub_h;

    logic [16:0] w_sum;
    logic [12:0] w_h;
    logic [15:0] sp_sum;
    logic [8:0]  sp_c;
    logic [4:0]  sp_h;

    logic [7:0]  inc_r;
    logic [7:0]  dec_r;
    logic [7:0]  bmask;

    logic [7:0]  daa_sub;
    logic [8:0]  daa_t1;
    logic [8:0]  daa_t2;
    logic [7:0]  daa_r;
    logic        daa_c;

    logic [7:0]  rot_r;
    logic        rot_c;

    logic [15:0] res;
    logic [3:0]  fo;
    logic [4:0]  cyc;

    assign fn  = func_t'(req.func);
    assign a16 = req.operand_a;
    assign b16 = req.operand_b;
    assign a   = req.operand_a[7:0];
    assign b   = req.operand_b[7:0];
    assign fi  = req.flags_in;
    assign cin = req.flags_in[FL_C];

    // Shared 8-bit adder and subtractor; carry/borrow in only for adc and sbc
    assign add_cin = (fn == FN_ADC) && cin;
    assign add_r   = {1'b0, a} + {1'b0, b} + {8'h00, add_cin};
    assign add_h   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, add_cin};
    assign sub_bin = (fn == FN_SBC) && cin;
    assign sub_r   = {1'b0, a} - {1'b0, b} - {8'h00, sub_bin};
    assign sub_h   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, sub_bin};

    // 16-bit add and stack pointer plus signed offset
    assign w_sum  = {1'b0, a16} + {1'b0, b16};
    assign w_h    = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    assign sp_sum = a16 + {{8{b[7]}}, b};
    assign sp_c   = {1'b0, a16[7:0]} + {1'b0, b};
    assign sp_h   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};

    assign inc_r = a + 8'h01;
    assign dec_r = a - 8'h01;
    assign bmask = 8'h01 << req.bit_index;

    // Decimal adjust: subtract path takes fixed corrections, add path tests digits
    assign daa_sub = a - (fi[FL_H] ? DAA_LO[7:0] : 8'h00) - (fi[FL_C] ? DAA_HI[7:0] : 8'h00);
    assign daa_t1  = {1'b0, a} + ((fi[FL_H] || (a[3:0] > 4'h9)) ? DAA_LO : 9'h000);
    assign daa_t2  = daa_t1 + ((fi[FL_C] || (daa_t1 > DAA_HI_LIM)) ? DAA_HI : 9'h000);
    assign daa_r   = fi[FL_N] ? daa_sub : daa_t2[7:0];
    assign daa_c   = fi[FL_C] | (~fi[FL_N] & daa_t2[8]);

    // Rotate and shift unit, shared by accumulator and prefixed forms
    always_comb
    begin
        rot_r = {1'b0, a[7:1]};
        rot_c = a[0];
        case (fn)
            FN_RLA, FN_RL:
            begin
                rot_r = {a[6:0], cin};
                rot_c = a[7];
            end
            FN_RRA, FN_RR:
            begin
                rot_r = {cin, a[7:1]};
                rot_c = a[0];
            end
            FN_RLCA, FN_RLC:
            begin
                rot_r = {a[6:0], a[7]};
                rot_c = a[7];
            end
            FN_RRCA, FN_RRC:
            begin
                rot_r = {a[0], a[7:1]};
                rot_c = a[0];
            end
            FN_SLA:
            begin
                rot_r = {a[6:0], 1'b0};
                rot_c = a[7];
            end
            FN_SRA:
            begin
                rot_r = {a[7], a[7:1]};
                rot_c = a[0];
            end
            default:
            begin
                rot_r = {1'b0, a[7:1]};
                rot_c = a[0];
            end
        endcase
    end

    // Select result, flags and cycle count by operation
    always_comb
    begin
        res = 16'h0000;
        fo  = fi;
        cyc = CYC_4;
        case (fn)
            FN_ADD, FN_ADC:
            begin
                res = {8'h00, add_r[7:0]};
                fo  = {zf(add_r[7:0]), 1'b0, add_h[4], add_r[8]};
            end
            FN_SUB, FN_SBC:
            begin
                res = {8'h00, sub_r[7:0]};
                fo  = {zf(sub_r[7:0]), 1'b1, sub_h[4], sub_r[8]};
            end
            FN_CP:
            begin
                res = a16;
                fo  = {zf(sub_r[7:0]), 1'b1, sub_h[4], sub_r[8]};
            end
            FN_AND:
            begin
                res = {8'h00, a & b};
                fo  = {zf(a & b), 1'b0, 1'b1, 1'b0};
            end
            FN_OR:
            begin
                res = {8'h00, a | b};
                fo  = {zf(a | b), 3'b000};
            end
            FN_XOR:
            begin
                res = {8'h00, a ^ b};
                fo  = {zf(a ^ b), 3'b000};
            end
            FN_INC8:
            begin
                res = {8'h00, inc_r};
                fo  = {zf(inc_r), 1'b0, (inc_r[3:0] == 4'h0), fi[FL_C]};
            end
            FN_DEC8:
            begin
                res = {8'h00, dec_r};
                fo  = {zf(dec_r), 1'b1, (dec_r[3:0] == 4'hF), fi[FL_C]};
            end
            FN_ADD16:
            begin
                res = w_sum[15:0];
                fo  = {fi[FL_Z], 1'b0, w_h[12], w_sum[16]};
                cyc = CYC_8;
            end
            FN_ADDSP:
            begin
                res = sp_sum;
                fo  = {2'b00, sp_h[4], sp_c[8]};
                cyc = CYC_16;
            end
            FN_INC16:
            begin
                res = a16 + 16'h0001;
                cyc = CYC_8;
            end
            FN_DEC16:
            begin
                res = a16 - 16'h0001;
                cyc = CYC_8;
            end
            FN_CPL:
            begin
                res = {8'h00, ~a};
                fo  = {fi[FL_Z], 1'b1, 1'b1, fi[FL_C]};
            end
            FN_DAA:
            begin
                res = {8'h00, daa_r};
                fo  = {zf(daa_r), fi[FL_N], 1'b0, daa_c};
            end
            FN_SWAP:
            begin
                res = {8'h00, a[3:0], a[7:4]};
                fo  = {zf(a), 3'b000};
                cyc = CYC_8;
            end
            FN_BIT:
            begin
                res = {8'h00, a};
                fo  = {~|(a & bmask), 1'b0, 1'b1, fi[FL_C]};
                cyc = CYC_8;
            end
            FN_SET:
            begin
                res = {8'h00, a | bmask};
                cyc = CYC_8;
            end
            FN_RES:
            begin
                res = {8'h00, a & ~bmask};
                cyc = CYC_8;
            end
            FN_RLA, FN_RRA, FN_RLCA, FN_RRCA:
            begin
                res = {8'h00, rot_r};
                fo  = {3'b000, rot_c};
            end
            FN_RL, FN_RR, FN_RLC, FN_RRC, FN_SLA, FN_SRA, FN_SRL:
            begin
                res = {8'h00, rot_r};
                fo  = {zf(rot_r), 2'b00, rot_c};
                cyc = CYC_8;
            end
            default:
            begin
                res = 16'h0000;
                fo  = fi;
                cyc = CYC_4;
            end
        endcase
    end

    assign rsp.result      = res;
    assign rsp.flags_out   = fo;
    assign rsp.cycle_count = cyc;

endmodule

`default_nettype wire

>>> hw/rtl/sm83_alu.sv
// sm83_alu: top level of the SM83 ALU, input register, datapath, result register.
// Depends on sm83_pkg, sm83_cmd_if, sm83_rsp_if and sm83_core.
//
//   channel  dir   payload                                          per transfer
//   cmd      in    func, operand_a, operand_b, bit_index, flags_in  one operation
//   rsp      out   result, flags_out, cycle_count                   one result
//
// An operation passes the input register, the combinational sm83_core and the result
// register to rsp; one operation per cycle is sustained while rsp.ready is high.
// Reset clears only the two stage valid flags; data registers are not reset.
// When rsp stalls, the result register holds and the input register fills, then
// cmd.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sm83_alu
    import sm83_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    sm83_cmd_if.sink    cmd,
    sm83_rsp_if.source  rsp
);

    alu_req_t req_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_rsp_t rsp_reg;
    alu_rsp_t rsp_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     cmd_xfer;
    logic     rsp_xfer;
    logic     out_load;

    // Handshake control
    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || !out_valid_reg || rsp.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign rsp_xfer  = out_valid_reg && rsp.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the operation on each cmd transfer
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            req_reg.func      <= cmd.func;
            req_reg.operand_a <= cmd.operand_a;
            req_reg.operand_b <= cmd.operand_b;
            req_reg.bit_index <= cmd.bit_index;
            req_reg.flags_in  <= cmd.flags_in;
        end
    end

    sm83_core u_core (
        .req (req_reg),
        .rsp (rsp_next)
    );

    // Advance the result register when the output is free
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result      = rsp_reg.result;
    assign rsp.flags_out   = rsp_reg.flags_out;
    assign rsp.cycle_count = rsp_reg.cycle_count;

    // Input may only stall behind a full input stage and a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("cmd stalled without a blocked pipeline");

    // An accepted operation occupies the input stage next cycle
    a_cmd_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> s1_valid_reg)
        else $error("accepted operation lost from input stage");

    // A held input stage moves to the output when it is free
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (!out_valid_reg || rsp.ready)) |=> out_valid_reg)
        else $error("result not loaded into output register");

    // Cycle counts are always one of the three reported lengths
    a_cycle_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.cycle_count == CYC_4 || rsp.cycle_count == CYC_8
                       || rsp.cycle_count == CYC_16))
        else $error("illegal cycle count on rsp");

endmodule

`default_nettype wire

>>> tb/sv/tb_sm83_alu.sv
// tb_sm83_alu: self-checking bench for the SM83 ALU, with its own predictor of every
// operation, a queue-fed command driver, a checking result monitor and a watchdog.
// Depends on sm83_pkg, sm83_cmd_if, sm83_rsp_if and sm83_alu.
`timescale 1ns / 1ps

module tb_sm83_alu;
    import sm83_pkg::*;

    localparam logic [4:0] FN_UNUSED  = 5'd31;
    localparam int         STALL_LONG = 64;
    localparam int         IDLE_LIMIT = 1000;
    localparam int         PRINT_MAX  = 50;

    logic clk = 1'b0;
    logic rst_n;

    sm83_cmd_if cmd_if ();
    sm83_rsp_if rsp_if ();

    sm83_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    alu_req_t    ops_to_issue[$];
    alu_rsp_t    alu_results_due[$];
    logic [4:0]  funcs_due[$];
    alu_req_t    next_op;
    alu_rsp_t    want;
    logic [4:0]  want_func;
    logic [31:0] funcs_seen;

    int   ops_sent;
    int   results_checked;
    int   mismatches;
    int   cmd_gap;
    int   rsp_hold;
    int   idle_cycles;
    logic random_idle;
    logic long_hold_req;
    logic long_hold_done;

    always #5 clk = ~clk;

    // Compute the result, flags and cycle count of one ALU operation
    function automatic alu_rsp_t compute_alu(alu_req_t op);
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic        cin;
        logic        carry_used;
        logic [8:0]  wide;
        logic [4:0]  half;
        logic [16:0] wide16;
        logic [12:0] half12;
        logic [15:0] daa_t;
        logic [7:0]  r8;
        logic        cout;
        logic        is_shift;
        alu_rsp_t    rsp;
        a8 = op.operand_a[7:0];
        b8 = op.operand_b[7:0];
        cin = op.flags_in[FL_C];
        is_shift = 1'b0;
        r8 = 8'h00;
        cout = 1'b0;
        rsp.result = 16'h0000;
        rsp.flags_out = op.flags_in;
        rsp.cycle_count = CYC_4;
        case (op.func)
            FN_ADD, FN_ADC:
            begin
                carry_used = (op.func == FN_ADC) && cin;
                wide = {1'b0, a8} + {1'b0, b8} + {8'h00, carry_used};
                half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, carry_used};
                rsp.result = {8'h00, wide[7:0]};
                rsp.flags_out = {wide[7:0] == 8'h00, 1'b0, half[4], wide[8]};
            end
            FN_SUB, FN_SBC, FN_CP:
            begin
                carry_used = (op.func == FN_SBC) && cin;
                // bit 8 and bit 4 go high exactly when the subtraction borrows
                wide = {1'b0, a8} - {1'b0, b8} - {8'h00, carry_used};
                half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, carry_used};
                rsp.result = (op.func == FN_CP) ? op.operand_a : {8'h00, wide[7:0]};
                rsp.flags_out = {wide[7:0] == 8'h00, 1'b1, half[4], wide[8]};
            end
            FN_AND:
            begin
                r8 = a8 & b8;
                rsp.result = {8'h00, r8};
                rsp.flags_out = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            FN_OR, FN_XOR:
            begin
                r8 = (op.func == FN_OR) ? (a8 | b8) : (a8 ^ b8);
                rsp.result = {8'h00, r8};
                rsp.flags_out = {r8 == 8'h00, 3'b000};
            end
            FN_INC8:
            begin
                r8 = a8 + 8'h01;
                rsp.result = {8'h00, r8};
                rsp.flags_out = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cin};
            end
            FN_DEC8:
            begin
                r8 = a8 - 8'h01;
                rsp.result = {8'h00, r8};
                rsp.flags_out = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cin};
            end
            FN_ADD16:
            begin
                wide16 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
                half12 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
                rsp.result = wide16[15:0];
                rsp.flags_out = {op.flags_in[FL_Z], 1'b0, half12[12], wide16[16]};
                rsp.cycle_count = CYC_8;
            end
            FN_ADDSP:
            begin
                // offset is signed, but H and C come from the unsigned low byte
                wide = {1'b0, a8} + {1'b0, b8};
                half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
                rsp.result = op.operand_a + {{8{b8[7]}}, b8};
                rsp.flags_out = {2'b00, half[4], wide[8]};
                rsp.cycle_count = CYC_16;
            end
            FN_INC16, FN_DEC16:
            begin
                rsp.result = (op.func == FN_INC16) ? op.operand_a + 16'h0001
                                                   : op.operand_a - 16'h0001;
                rsp.cycle_count = CYC_8;
            end
            FN_CPL:
            begin
                rsp.result = {8'h00, ~a8};
                rsp.flags_out[FL_N] = 1'b1;
                rsp.flags_out[FL_H] = 1'b1;
            end
            FN_DAA:
            begin
                daa_t = {8'h00, a8};
                if (op.flags_in[FL_N])
                begin
                    if (op.flags_in[FL_H])
                        daa_t = (daa_t - 16'h0006) & 16'h00FF;
                    if (op.flags_in[FL_C])
                        daa_t = daa_t - 16'h0060;
                end
                else
                begin
                    if (op.flags_in[FL_H] || daa_t[3:0] > 4'h9)
                        daa_t = daa_t + 16'h0006;
                    if (op.flags_in[FL_C] || daa_t > 16'h009F)
                        daa_t = daa_t + 16'h0060;
                end
                rsp.result = {8'h00, daa_t[7:0]};
                rsp.flags_out = {daa_t[7:0] == 8'h00, op.flags_in[FL_N], 1'b0,
                                 cin | daa_t[8]};
            end
            FN_SWAP:
            begin
                r8 = {a8[3:0], a8[7:4]};
                rsp.result = {8'h00, r8};
                rsp.flags_out = {r8 == 8'h00, 3'b000};
                rsp.cycle_count = CYC_8;
            end
            FN_BIT:
            begin
                rsp.result = {8'h00, a8};
                rsp.flags_out = {~a8[op.bit_index], 1'b0, 1'b1, cin};
                rsp.cycle_count = CYC_8;
            end
            FN_SET, FN_RES:
            begin
                r8 = (op.func == FN_SET) ? (a8 | (8'h01 << op.bit_index))
                                         : (a8 & ~(8'h01 << op.bit_index));
                rsp.result = {8'h00, r8};
                rsp.cycle_count = CYC_8;
            end
            FN_RLA, FN_RL:
            begin
                is_shift = 1'b1;
                r8 = {a8[6:0], cin};
                cout = a8[7];
            end
            FN_RRA, FN_RR:
            begin
                is_shift = 1'b1;
                r8 = {cin, a8[7:1]};
                cout = a8[0];
            end
            FN_RLCA, FN_RLC:
            begin
                is_shift = 1'b1;
                r8 = {a8[6:0], a8[7]};
                cout = a8[7];
            end
            FN_RRCA, FN_RRC:
            begin
                is_shift = 1'b1;
                r8 = {a8[0], a8[7:1]};
                cout = a8[0];
            end
            FN_SLA:
            begin
                is_shift = 1'b1;
                r8 = {a8[6:0], 1'b0};
                cout = a8[7];
            end
            FN_SRA:
            begin
                is_shift = 1'b1;
                r8 = {a8[7], a8[7:1]};
                cout = a8[0];
            end
            FN_SRL:
            begin
                is_shift = 1'b1;
                r8 = {1'b0, a8[7:1]};
                cout = a8[0];
            end
            default:
            begin
                // unused code: zero result, flags pass through
                rsp.result = 16'h0000;
            end
        endcase
        // accumulator rotates always clear Z; the CB forms set it from the result
        if (is_shift)
        begin
            rsp.result = {8'h00, r8};
            if (op.func >= FN_RL)
            begin
                rsp.flags_out = {r8 == 8'h00, 2'b00, cout};
                rsp.cycle_count = CYC_8;
            end
            else
            begin
                rsp.flags_out = {3'b000, cout};
            end
        end
        return rsp;
    endfunction

    // Pick a byte, leaning toward carry and nibble boundaries
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            4: return 8'h0F;
            5: return 8'hF0;
            6: return 8'h99;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Pick a 16-bit operand: full range, edges, or a byte-sized value
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {8'h00, pick_byte()};
            3: return {8'($urandom_range(0, 255)), pick_byte()};
            4: return {4'($urandom_range(0, 15)), 12'hFFF};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Build one random operation; DAA often follows a real BCD add or subtract
    function automatic alu_req_t random_op();
        alu_req_t op;
        alu_req_t bcd_op;
        alu_rsp_t bcd_rsp;
        op.func = 5'($urandom_range(0, 31));
        op.operand_a = pick_word();
        op.operand_b = pick_word();
        op.bit_index = 3'($urandom_range(0, 7));
        op.flags_in = 4'($urandom_range(0, 15));
        if (op.func == FN_DAA && $urandom_range(0, 2) != 0)
        begin
            bcd_op.func = ($urandom_range(0, 1) != 0) ? FN_ADD : FN_SUB;
            if ($urandom_range(0, 1) != 0)
                bcd_op.func = (bcd_op.func == FN_ADD) ? FN_ADC : FN_SBC;
            bcd_op.operand_a = {8'h00, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            bcd_op.operand_b = {8'h00, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            bcd_op.bit_index = 3'd0;
            bcd_op.flags_in = 4'($urandom_range(0, 15));
            bcd_rsp = compute_alu(bcd_op);
            op.operand_a[7:0] = bcd_rsp.result[7:0];
            op.flags_in = bcd_rsp.flags_out;
        end
        return op;
    endfunction

    task automatic add_op(logic [4:0] f, logic [15:0] a, logic [15:0] b,
                          logic [2:0] bi, logic [3:0] fl);
        ops_to_issue.push_back('{func: f, operand_a: a, operand_b: b,
                                 bit_index: bi, flags_in: fl});
    endtask

    task automatic report_mismatch(string what, logic [4:0] f,
                                   logic [15:0] got, logic [15:0] exp_val);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("[%0t] func %0d %s: got %h, want %h", $time, f, what, got, exp_val);
    endtask

    // Drive commands from the queue with random idle bursts; hold until transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_gap <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                next_op = '{func: cmd_if.func, operand_a: cmd_if.operand_a,
                            operand_b: cmd_if.operand_b, bit_index: cmd_if.bit_index,
                            flags_in: cmd_if.flags_in};
                alu_results_due.push_back(compute_alu(next_op));
                funcs_due.push_back(next_op.func);
                funcs_seen[next_op.func] = 1'b1;
                ops_sent++;
            end
            if (cmd_if.valid && !cmd_if.ready)
            begin
                // hold the offered item
            end
            else if (cmd_gap != 0)
            begin
                cmd_gap <= cmd_gap - 1;
                cmd_if.valid <= 1'b0;
            end
            else if (ops_to_issue.size() != 0 && random_idle && $urandom_range(0, 7) == 0)
            begin
                cmd_gap <= $urandom_range(0, 8);
                cmd_if.valid <= 1'b0;
            end
            else if (ops_to_issue.size() != 0)
            begin
                next_op = ops_to_issue.pop_front();
                cmd_if.func <= next_op.func;
                cmd_if.operand_a <= next_op.operand_a;
                cmd_if.operand_b <= next_op.operand_b;
                cmd_if.bit_index <= next_op.bit_index;
                cmd_if.flags_in <= next_op.flags_in;
                cmd_if.valid <= 1'b1;
            end
            else
            begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Check each result transfer, then choose ready for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (alu_results_due.size() == 0)
                begin
                    report_mismatch("result with none expected", 5'd0, rsp_if.result, 16'h0);
                end
                else
                begin
                    want = alu_results_due.pop_front();
                    want_func = funcs_due.pop_front();
                    results_checked++;
                    if (rsp_if.result !== want.result)
                        report_mismatch("result", want_func, rsp_if.result, want.result);
                    if (rsp_if.flags_out !== want.flags_out)
                        report_mismatch("flags", want_func, 16'(rsp_if.flags_out),
                                        16'(want.flags_out));
                    if (rsp_if.cycle_count !== want.cycle_count)
                        report_mismatch("cycle count", want_func, 16'(rsp_if.cycle_count),
                                        16'(want.cycle_count));
                end
            end
            if (rsp_hold != 0)
            begin
                rsp_hold <= rsp_hold - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                // long stall so the pipeline fills and cmd.ready drops
                rsp_hold <= STALL_LONG - 1;
                long_hold_done <= 1'b1;
                rsp_if.ready <= 1'b0;
            end
            else if (random_idle && $urandom_range(0, 7) == 0)
            begin
                rsp_hold <= $urandom_range(0, 8);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_sm83_alu: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.func = 5'd0;
        cmd_if.operand_a = 16'h0000;
        cmd_if.operand_b = 16'h0000;
        cmd_if.bit_index = 3'd0;
        cmd_if.flags_in = 4'h0;
        rsp_if.ready = 1'b0;
        random_idle = 1'b0;
        long_hold_req = 1'b0;
        funcs_seen = '0;
        ops_sent = 0;
        results_checked = 0;
        mismatches = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every code at least once, at carry, borrow and zero corners
        add_op(FN_ADD,    16'h00FF, 16'h0001, 3'd0, 4'h0);
        add_op(FN_ADC,    16'hAB0F, 16'hCD00, 3'd0, 4'h1);
        add_op(FN_SUB,    16'h0010, 16'h0001, 3'd0, 4'h0);
        add_op(FN_SBC,    16'h0000, 16'h00FF, 3'd0, 4'h1);
        add_op(FN_SBC,    16'h0010, 16'h000F, 3'd0, 4'h1);
        add_op(FN_CP,     16'hFF12, 16'h0012, 3'd0, 4'h0);
        add_op(FN_AND,    16'hFFF0, 16'hFF0F, 3'd0, 4'hF);
        add_op(FN_OR,     16'h0000, 16'h0000, 3'd0, 4'hF);
        add_op(FN_XOR,    16'h00FF, 16'hFFFF, 3'd0, 4'h0);
        add_op(FN_INC8,   16'h12FF, 16'h0000, 3'd0, 4'h1);
        add_op(FN_DEC8,   16'h0000, 16'h0000, 3'd0, 4'h0);
        add_op(FN_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'h8);
        add_op(FN_ADDSP,  16'h00FF, 16'h12FF, 3'd0, 4'hF);
        add_op(FN_ADDSP,  16'h8000, 16'h0080, 3'd0, 4'h0);
        add_op(FN_INC16,  16'hFFFF, 16'h0000, 3'd0, 4'hF);
        add_op(FN_DEC16,  16'h0000, 16'h0000, 3'd0, 4'h0);
        add_op(FN_CPL,    16'h005A, 16'h0000, 3'd0, 4'h0);
        add_op(FN_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0);
        add_op(FN_DAA,    16'h0000, 16'h0000, 3'd0, 4'h7);
        add_op(FN_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'hF);
        add_op(FN_BIT,    16'h007F, 16'h0000, 3'd7, 4'h0);
        add_op(FN_SET,    16'h0000, 16'h0000, 3'd7, 4'h5);
        add_op(FN_RES,    16'hFFFF, 16'h0000, 3'd0, 4'hA);
        add_op(FN_RLA,    16'h0080, 16'h0000, 3'd0, 4'h8);
        add_op(FN_RRA,    16'h0001, 16'h0000, 3'd0, 4'h1);
        add_op(FN_RLCA,   16'h0080, 16'h0000, 3'd0, 4'h0);
        add_op(FN_RRCA,   16'h0001, 16'h0000, 3'd0, 4'h0);
        add_op(FN_RL,     16'h0080, 16'h0000, 3'd0, 4'h0);
        add_op(FN_RR,     16'h0001, 16'h0000, 3'd0, 4'h0);
        add_op(FN_RLC,    16'h0000, 16'h0000, 3'd0, 4'hF);
        add_op(FN_RRC,    16'h00FF, 16'h0000, 3'd0, 4'h0);
        add_op(FN_SLA,    16'h0080, 16'h0000, 3'd0, 4'h0);
        add_op(FN_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0);
        add_op(FN_SRL,    16'h0001, 16'h0000, 3'd0, 4'hF);
        add_op(FN_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);

        // Random with idling on both sides; one long output stall midway
        random_idle = 1'b1;
        for (n = 0; n < 900; n++)
            ops_to_issue.push_back(random_op());
        while (ops_to_issue.size() > 500)
            @(negedge clk);
        long_hold_req = 1'b1;
        while (ops_to_issue.size() != 0)
            @(negedge clk);

        // Last stretch at full rate, no idling
        random_idle = 1'b0;
        for (n = 0; n < 350; n++)
            ops_to_issue.push_back(random_op());
        while (ops_to_issue.size() != 0 || cmd_if.valid || alu_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d operations over %0d of 32 function codes, %0d results checked,",
                 ops_sent, $countones(funcs_seen), results_checked);
        $display("with random idling, one %0d-cycle output stall and a full-rate finish.",
                 STALL_LONG);
        if (mismatches == 0)
            $display("tb_sm83_alu: clean");
        else
            $display("tb_sm83_alu: errors");
        $finish;
    end

endmodule

>>> sm83_alu.f
hw/rtl/sm83_pkg.sv
hw/rtl/sm83_cmd_if.sv
hw/rtl/sm83_rsp_if.sv
hw/rtl/sm83_core.sv
hw/rtl/sm83_alu.sv
tb/sv/tb_sm83_alu.sv
